// ===== design/bilinear_texture_sampler_assert.svh =====
// Assertion macros for the bilinear texture sampler checker.
// Needs clk_i and rst_ni visible where a macro is used.
`ifndef BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH
`define BILINEAR_TEXTURE_SAMPLER_ASSERT_SVH

// Assert a property on the rising clock, off while reset is low.
`define BTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assert that a condition in one cycle implies another in the next.
`define BTS_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== design/bts_pkg.sv =====
// Shared types and constants of the bilinear texture sampler.
// No dependencies.
`default_nettype none
package bts_pkg;

  localparam int unsigned XW        = 8;             // texel column bits
  localparam int unsigned YW        = 8;             // texel row bits
  localparam int unsigned MAX_W     = 1 << XW;
  localparam int unsigned MAX_H     = 1 << YW;
  localparam int unsigned CH_BITS   = 16;
  localparam int unsigned WB        = 8;             // weight fraction bits
  localparam int unsigned CW        = 17;            // Q1.16 coordinate
  localparam int unsigned SW        = 9;             // size register width
  localparam int unsigned PW        = SW + CW;       // size * coord
  localparam int unsigned WW        = 2 * WB + 1;    // blend weight
  localparam int unsigned TW        = 3 * CH_BITS;   // one RGB texel
  localparam int unsigned BAW       = (XW - 1) + (YW - 1);
  localparam int unsigned BANK_DEPTH = 1 << BAW;
  localparam int unsigned PRODW     = CH_BITS + WW;
  localparam int unsigned SUMW      = PRODW + 2;

  localparam logic [CW-1:0] ONE_Q16  = CW'(65536);
  localparam logic [PW-1:0] HALF_Q16 = PW'(32768);

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;
  localparam logic MODE_NEAREST = 1'b0;
  localparam logic MODE_BILINEAR = 1'b1;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_MODE   = 2'd2
  } cfg_idx_e;

  // Request after index and weight selection.
  typedef struct packed {
    logic              kind;
    logic [XW-1:0]     ix;
    logic [YW-1:0]     iy;
    logic [WB-1:0]     fx;
    logic [WB-1:0]     fy;
    logic [XW-1:0]     wx;
    logic [YW-1:0]     wy;
    logic [TW-1:0]     wdata;
  } coord_t;

  // Side data that travels beside the store read.
  typedef struct packed {
    logic          ix0;
    logic          iy0;
    logic [WB-1:0] fx;
    logic [WB-1:0] fy;
  } fetch_t;

endpackage
`default_nettype wire

// ===== design/bilinear_texture_sampler.sv =====
// Bilinear texture sampler top level: config registers and pipeline wiring.
// Depends on bts_pkg, bts_coord, bts_store, bts_blend, bts_outq.
//
// Usage: requests arrive on the s_axis channel. tuser is the kind: 0 writes
// one RGB texel at (texel_x, texel_y) into a 256x256 store and gives no
// result; 1 samples at Q1.16 (u, v) and gives one RGB result on m_axis.
// Nearest or bilinear filtering and the texture size in use come from the
// write-only config port (0 width, 1 height, 2 filter mode).
// Throughput: one request per cycle while the output queue has room; the store
// is four parity banks so the four neighbors of a sample are read together.
// Path: a sample passes two coordinate stages, the bank read, three blend
// stages and the output queue before it shows on m_axis.
// A write is visible to any sample accepted in a later cycle.
// Reset: config returns to 256 x 256 bilinear; pipeline and queue empty.
// Texel contents are not cleared; unwritten texels read as unknown.
// Stall: a two-entry queue holds results; when it is full the whole
// pipeline holds and s_axis_tready drops, nothing is lost or repeated.
`default_nettype none
module bilinear_texture_sampler (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // x[7:0] y[15:8] red[31:16] green[47:32] blue[63:48] u[80:64] v[97:81], zero pad
  input  wire logic [103:0] s_axis_tdata,
  // kind[0]
  input  wire logic [0:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // red[15:0] green[31:16] blue[47:32]
  output logic [47:0]       m_axis_tdata,
  input  wire logic         cfg_we_i,
  input  wire logic [1:0]   cfg_idx_i,
  input  wire logic [8:0]   cfg_data_i
);
  import bts_pkg::*;

  logic [SW-1:0] tex_width_q, tex_height_q;
  logic          filter_mode_q;
  logic          en;
  logic          vb, vc, vf;
  coord_t        cb;
  fetch_t        fc;
  logic [TW-1:0] bank [4];
  logic [TW-1:0] rgb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q   <= SW'(256);
      tex_height_q  <= SW'(256);
      filter_mode_q <= MODE_BILINEAR;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WIDTH:  tex_width_q   <= cfg_data_i;
        CFG_HEIGHT: tex_height_q  <= cfg_data_i;
        CFG_MODE:   filter_mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = en;

  bts_coord u_coord (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (en),
    .valid_i       (s_axis_tvalid),
    .kind_i        (s_axis_tuser[0]),
    .texel_x_i     (s_axis_tdata[7:0]),
    .texel_y_i     (s_axis_tdata[15:8]),
    .wdata_i       (s_axis_tdata[63:16]),
    .coord_u_i     (s_axis_tdata[80:64]),
    .coord_v_i     (s_axis_tdata[97:81]),
    .tex_width_i   (tex_width_q),
    .tex_height_i  (tex_height_q),
    .filter_mode_i (filter_mode_q),
    .valid_o       (vb),
    .coord_o       (cb)
  );

  bts_store u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vb),
    .coord_i (cb),
    .valid_o (vc),
    .fetch_o (fc),
    .bank_o  (bank)
  );

  bts_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (vc),
    .fetch_i (fc),
    .bank_i  (bank),
    .valid_o (vf),
    .rgb_o   (rgb)
  );

  bts_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && vf),
    .data_i  (rgb),
    .room_o  (en),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule
`default_nettype wire

// ===== design/bts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bts_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16384
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== design/bts_coord.sv =====
// Coordinate stages: clamp and scale u,v, then pick texel indices and weights.
// Depends on bts_pkg.
`default_nettype none
module bts_coord (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire logic                  kind_i,
  input  wire logic [bts_pkg::XW-1:0] texel_x_i,
  input  wire logic [bts_pkg::YW-1:0] texel_y_i,
  input  wire logic [bts_pkg::TW-1:0] wdata_i,
  input  wire logic [bts_pkg::CW-1:0] coord_u_i,
  input  wire logic [bts_pkg::CW-1:0] coord_v_i,
  input  wire logic [bts_pkg::SW-1:0] tex_width_i,
  input  wire logic [bts_pkg::SW-1:0] tex_height_i,
  input  wire logic                  filter_mode_i,
  output logic                       valid_o,
  output bts_pkg::coord_t            coord_o
);
  import bts_pkg::*;

  // Stage A: products
  logic           va_q;
  logic           kind_q, mode_q;
  logic [XW-1:0]  wx_q;
  logic [YW-1:0]  wy_q;
  logic [TW-1:0]  wdata_q;
  logic [PW-1:0]  px_q, py_q;
  logic [SW-1:0]  sx_q, sy_q;
  logic [SW-1:0]  sx_d, sy_d;
  logic [CW-1:0]  u_c, v_c;

  // Stage B
  logic    vb_q;
  coord_t  cb_q, cb_d;

  function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] v, input logic [SW-1:0] mx);
    logic [SW-1:0] r;
    r = v;
    if (v == '0) r = SW'(1);
    else if (v > mx) r = mx;
    return r;
  endfunction

  always_comb begin
    sx_d = eff_size(tex_width_i, SW'(MAX_W));
    sy_d = eff_size(tex_height_i, SW'(MAX_H));
    u_c  = (coord_u_i > ONE_Q16) ? ONE_Q16 : coord_u_i;
    v_c  = (coord_v_i > ONE_Q16) ? ONE_Q16 : coord_v_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      kind_q  <= kind_i;
      mode_q  <= filter_mode_i;
      wx_q    <= texel_x_i;
      wy_q    <= texel_y_i;
      wdata_q <= wdata_i;
      sx_q    <= sx_d;
      sy_q    <= sy_d;
      px_q    <= PW'(sx_d) * PW'(u_c);
      py_q    <= PW'(sy_d) * PW'(v_c);
      cb_q    <= cb_d;
    end
  end

  // Index and weight along one axis; nearest mode keeps the weight at zero.
  function automatic logic [SW+WB-1:0] axis(input logic [PW-1:0] p, input logic [SW-1:0] sz,
                                            input logic mode);
    logic [PW-1:0]    xs;
    logic [PW-16-1:0] q;
    logic [SW-1:0]    lim, ix;
    logic [WB-1:0]    wt;
    logic             neg;
    neg = (p < HALF_Q16);
    xs  = p - HALF_Q16;
    lim = sz - SW'(1);
    q   = (mode == MODE_NEAREST) ? p[PW-1:16] : xs[PW-1:16];
    if (mode != MODE_NEAREST && neg) begin
      q = '0;
    end
    ix = (q > (PW-16)'(lim)) ? lim : SW'(q);
    wt = xs[15 -: WB];
    if (mode == MODE_NEAREST || neg || ix == lim) begin
      wt = '0;
    end
    return {ix, wt};
  endfunction

  always_comb begin
    logic [SW+WB-1:0] ax, ay;
    ax = axis(px_q, sx_q, mode_q);
    ay = axis(py_q, sy_q, mode_q);
    cb_d.kind  = kind_q;
    cb_d.ix    = ax[WB +: XW];
    cb_d.fx    = ax[WB-1:0];
    cb_d.iy    = ay[WB +: YW];
    cb_d.fy    = ay[WB-1:0];
    cb_d.wx    = wx_q;
    cb_d.wy    = wy_q;
    cb_d.wdata = wdata_q;
  end

  assign valid_o = vb_q;
  assign coord_o = cb_q;

endmodule
`default_nettype wire

// ===== design/bts_store.sv =====
// Texel store: four RAM banks split by column and row parity.
// Depends on bts_pkg and bts_ram.
`default_nettype none
module bts_store (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  en_i,
  input  wire logic                  valid_i,
  input  wire bts_pkg::coord_t       coord_i,
  output logic                       valid_o,
  output bts_pkg::fetch_t            fetch_o,
  output logic [bts_pkg::TW-1:0]     bank_o [4]
);
  import bts_pkg::*;

  logic [XW:0]  col_e, col_o;
  logic [YW:0]  row_e, row_o;
  logic         vc_q;
  fetch_t       fc_q;

  always_comb begin
    col_e = coord_i.ix[0] ? ({1'b0, coord_i.ix} + (XW+1)'(1)) : {1'b0, coord_i.ix};
    col_o = coord_i.ix[0] ? {1'b0, coord_i.ix} : ({1'b0, coord_i.ix} + (XW+1)'(1));
    row_e = coord_i.iy[0] ? ({1'b0, coord_i.iy} + (YW+1)'(1)) : {1'b0, coord_i.iy};
    row_o = coord_i.iy[0] ? {1'b0, coord_i.iy} : ({1'b0, coord_i.iy} + (YW+1)'(1));
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [XW:0]    col;
    logic [YW:0]    row;
    logic [BAW-1:0] raddr, waddr;
    logic           we;
    assign col   = b[0] ? col_o : col_e;
    assign row   = b[1] ? row_o : row_e;
    // out-of-image neighbors wrap; their data is replaced downstream
    assign raddr = {row[YW-1:1], col[XW-1:1]};
    assign waddr = {coord_i.wy[YW-1:1], coord_i.wx[XW-1:1]};
    assign we    = en_i && valid_i && (coord_i.kind == KIND_WRITE)
                   && (coord_i.wy[0] == b[1]) && (coord_i.wx[0] == b[0]);
    bts_ram #(
      .WIDTH(TW),
      .DEPTH(BANK_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (waddr),
      .wdata_i (coord_i.wdata),
      .re_i    (en_i),
      .raddr_i (raddr),
      .rdata_o (bank_o[b])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vc_q <= 1'b0;
    end else if (en_i) begin
      vc_q <= valid_i && (coord_i.kind == KIND_SAMPLE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      fc_q.ix0 <= coord_i.ix[0];
      fc_q.iy0 <= coord_i.iy[0];
      fc_q.fx  <= coord_i.fx;
      fc_q.fy  <= coord_i.fy;
    end
  end

  assign valid_o = vc_q;
  assign fetch_o = fc_q;

endmodule
`default_nettype wire

// ===== design/bts_blend.sv =====
// Blend stages: pick the four neighbors, form weights, multiply and sum.
// Depends on bts_pkg.
`default_nettype none
module bts_blend (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     en_i,
  input  wire logic                     valid_i,
  input  wire bts_pkg::fetch_t          fetch_i,
  input  wire logic [bts_pkg::TW-1:0]   bank_i [4],
  output logic                          valid_o,
  output logic [bts_pkg::TW-1:0]        rgb_o
);
  import bts_pkg::*;

  logic [TW-1:0]    t_d [4];
  logic [TW-1:0]    t_q [4];
  logic [WW-1:0]    w_d [4];
  logic [WW-1:0]    w_q [4];
  logic [PRODW-1:0] p_q [4][3];
  logic [TW-1:0]    rgb_q, rgb_d;
  logic             vd_q, ve_q, vf_q;
  logic [WB:0]      sfx, sfy;

  always_comb begin
    logic [1:0] i00, i10, i01, i11;
    i00 = {fetch_i.iy0, fetch_i.ix0};
    i10 = {fetch_i.iy0, ~fetch_i.ix0};
    i01 = {~fetch_i.iy0, fetch_i.ix0};
    i11 = {~fetch_i.iy0, ~fetch_i.ix0};
    // edge replication: a zero weight reuses the nearer texel
    t_d[0] = bank_i[i00];
    t_d[1] = (fetch_i.fx == '0) ? t_d[0] : bank_i[i10];
    t_d[2] = (fetch_i.fy == '0) ? t_d[0] : bank_i[i01];
    t_d[3] = (fetch_i.fy == '0) ? t_d[1] :
             ((fetch_i.fx == '0) ? t_d[2] : bank_i[i11]);
    sfx = (WB+1)'(1 << WB) - (WB+1)'(fetch_i.fx);
    sfy = (WB+1)'(1 << WB) - (WB+1)'(fetch_i.fy);
    w_d[0] = WW'(sfx * sfy);
    w_d[1] = WW'((WB+1)'(fetch_i.fx) * sfy);
    w_d[2] = WW'(sfx * (WB+1)'(fetch_i.fy));
    w_d[3] = WW'((WB+1)'(fetch_i.fx) * (WB+1)'(fetch_i.fy));
  end

  always_comb begin
    logic [SUMW-1:0] s;
    for (int c = 0; c < 3; c++) begin
      s = SUMW'(p_q[0][c]) + SUMW'(p_q[1][c]) + SUMW'(p_q[2][c]) + SUMW'(p_q[3][c]);
      rgb_d[c*CH_BITS +: CH_BITS] = s[2*WB +: CH_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vd_q <= 1'b0;
      ve_q <= 1'b0;
      vf_q <= 1'b0;
    end else if (en_i) begin
      vd_q <= valid_i;
      ve_q <= vd_q;
      vf_q <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 4; k++) begin
        t_q[k] <= t_d[k];
        w_q[k] <= w_d[k];
        for (int c = 0; c < 3; c++) begin
          p_q[k][c] <= PRODW'(t_q[k][c*CH_BITS +: CH_BITS]) * PRODW'(w_q[k]);
        end
      end
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = vf_q;
  assign rgb_o   = rgb_q;

endmodule
`default_nettype wire

// ===== design/bts_outq.sv =====
// Two-entry output queue; its fill level sets the pipeline advance.
// Depends on bts_pkg.
`default_nettype none
module bts_outq (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [bts_pkg::TW-1:0] data_i,
  output logic                      room_o,
  output logic                      valid_o,
  input  wire logic                 ready_i,
  output logic [bts_pkg::TW-1:0]    data_o
);
  import bts_pkg::*;

  logic [TW-1:0] mem_q [2];
  logic          wp_q, rp_q;
  logic [1:0]    cnt_q, cnt_d;
  logic          pop;

  assign valid_o = (cnt_q != 2'd0);
  assign room_o  = (cnt_q != 2'd2);
  assign pop     = valid_o && ready_i;
  assign data_o  = mem_q[rp_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) cnt_d = cnt_q + 2'd1;
    else if (pop && !push_i) cnt_d = cnt_q - 2'd1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) wp_q <= ~wp_q;
      if (pop)    rp_q <= ~rp_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wp_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== design/bts_checker.sv =====
// Port-level checks of the bilinear texture sampler, bound to the top level.
// Depends on bilinear_texture_sampler_assert.svh.
`default_nettype none
`include "bilinear_texture_sampler_assert.svh"
module bts_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [103:0] s_axis_tdata,
  input wire logic [0:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [47:0]  m_axis_tdata,
  input wire logic         cfg_we_i,
  input wire logic [1:0]   cfg_idx_i,
  input wire logic [8:0]   cfg_data_i
);

  logic unused;
  assign unused = s_axis_tvalid ^ (^s_axis_tdata) ^ s_axis_tuser[0] ^ cfg_we_i
                  ^ (^cfg_idx_i) ^ (^cfg_data_i);

  // input only holds back while results are queued
  `BTS_ASSERT(a_stall_has_result, !s_axis_tready |-> m_axis_tvalid, "stall without result")
  // ready returns only after a result was taken
  `BTS_ASSERT(a_ready_after_pop, $rose(s_axis_tready) |-> $past(m_axis_tvalid && m_axis_tready),
              "ready rose without pop")
  `BTS_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
                   m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
  `BTS_ASSERT(a_out_drop, $fell(m_axis_tvalid) |-> $past(m_axis_tready), "result dropped")

endmodule

bind bilinear_texture_sampler bts_checker u_bts_checker (.*);
`default_nettype wire
